// ===== src/bmg_pkg.sv =====
// Shared constants and latency figures for the Box-Muller Gaussian pair unit.
package bmg_pkg;

    // Default number of fraction bits of mean, deviation and samples
    localparam int FRAC_BITS_DEF = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_MEAN  = 2'd0;
    localparam logic [1:0] CFG_STD   = 2'd1;
    localparam logic [1:0] CFG_ROUND = 2'd2;

    // Configuration reset values
    localparam logic [31:0] STD_RESET = 32'h0001_0000;

    // Fixed-point constants: 2 ln 2 in Q.30, pi in Q.29, one in Q.30
    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
    localparam logic [30:0] PI_Q29      = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    // Radius pipeline shape
    localparam int SQ_STEPS   = 30;
    localparam int SQRT_STEPS = 31;
    localparam int RAD_LAT    = 3 + SQ_STEPS + 3 + SQRT_STEPS;

    // Trig pipeline shape: three front stages, two stages per series term
    localparam int SIN_TERMS = 5;
    localparam int COS_TERMS = 6;
    localparam int TRIG_LAT  = 3 + 2 * COS_TERMS;

    // Output scaling stages and total latency
    localparam int FIN_LAT   = 5;
    localparam int TOTAL_LAT = RAD_LAT + FIN_LAT;

    // Exact constant division of a 30-bit value: q / d = (q * RECIP) >> SHIFT
    localparam int unsigned SIN_SHIFT [SIN_TERMS] = '{37, 37, 36, 35, 33};
    localparam logic [30:0] SIN_RECIP [SIN_TERMS] = '{
        31'(((64'd1 << 37) + 64'd109) / 64'd110),
        31'(((64'd1 << 37) + 64'd71) / 64'd72),
        31'(((64'd1 << 36) + 64'd41) / 64'd42),
        31'(((64'd1 << 35) + 64'd19) / 64'd20),
        31'(((64'd1 << 33) + 64'd5) / 64'd6)
    };
    localparam int unsigned COS_SHIFT [COS_TERMS] = '{38, 37, 36, 35, 34, 31};
    localparam logic [30:0] COS_RECIP [COS_TERMS] = '{
        31'(((64'd1 << 38) + 64'd131) / 64'd132),
        31'(((64'd1 << 37) + 64'd89) / 64'd90),
        31'(((64'd1 << 36) + 64'd55) / 64'd56),
        31'(((64'd1 << 35) + 64'd29) / 64'd30),
        31'(((64'd1 << 34) + 64'd11) / 64'd12),
        31'(((64'd1 << 31) + 64'd1) / 64'd2)
    };

endpackage

// ===== src/bmg_radius.sv =====
// Radius pipeline: C = sqrt(-2 ln u) in Q.28 from the radius word.
module bmg_radius import bmg_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_word,
    output logic [30:0] o_radius
);

    logic [32:0] r_x;
    logic [32:0] r_x1;
    logic [5:0]  r_e1;
    logic [5:0]  n_e1;
    logic [62:0] norm_shift;

    logic [30:0] r_m  [SQ_STEPS+1];
    logic [29:0] r_fr [SQ_STEPS+1];
    logic [5:0]  r_e  [SQ_STEPS+1];

    logic [35:0] r_n;
    logic [47:0] r_p_hi;
    logic [47:0] r_p_lo;
    logic [64:0] rad_sum;

    logic [63:0] r_rem  [SQRT_STEPS+1];
    logic [30:0] r_root [SQRT_STEPS+1];

    // Offset the word by one
    always_ff @(posedge i_clk) begin
        r_x <= 33'(i_word) + 33'd1;
    end

    // Find the msb index of the offset word
    always_comb begin
        n_e1 = '0;
        for (int i = 0; i < 33; i++) begin
            if (r_x[i]) begin
                n_e1 = 6'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1 <= r_x;
        r_e1 <= n_e1;
    end

    // Normalize the mantissa to Q1.30
    assign norm_shift = {r_x1, 30'd0} >> r_e1;

    always_ff @(posedge i_clk) begin
        r_m[0]  <= norm_shift[30:0];
        r_fr[0] <= '0;
        r_e[0]  <= r_e1;
    end

    // Square the mantissa once per stage, one fraction bit of log2 each
    for (genvar g = 1; g <= SQ_STEPS; g++) begin : g_sq
        logic [61:0] sq;
        logic [31:0] sq_hi;
        assign sq    = r_m[g-1] * r_m[g-1];
        assign sq_hi = sq[61:30];
        always_ff @(posedge i_clk) begin
            r_m[g]  <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
            r_fr[g] <= {r_fr[g-1][28:0], sq_hi[31]};
            r_e[g]  <= r_e[g-1];
        end
    end

    // Form -log2(u) in Q.30
    always_ff @(posedge i_clk) begin
        r_n <= (36'd32 << 30) - {r_e[SQ_STEPS], r_fr[SQ_STEPS]};
    end

    // Scale by 2 ln 2 in two partial products
    always_ff @(posedge i_clk) begin
        r_p_hi <= 48'(r_n[35:19] * TWO_LN2_Q30);
        r_p_lo <= 48'(r_n[18:2] * TWO_LN2_Q30);
    end

    assign rad_sum = {r_p_hi, 17'd0} + 65'(r_p_lo);

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= {2'd0, rad_sum[63:28], 26'd0};
        r_root[0] <= '0;
    end

    // Resolve one root bit per stage, msb first
    for (genvar g = 1; g <= SQRT_STEPS; g++) begin : g_sqrt
        localparam int K = SQRT_STEPS - g;
        logic [63:0] trial;
        assign trial = (64'(r_root[g-1]) << (K + 1)) + (64'd1 << (2 * K));
        always_ff @(posedge i_clk) begin
            if (r_rem[g-1] >= trial) begin
                r_rem[g]  <= r_rem[g-1] - trial;
                r_root[g] <= r_root[g-1] | (31'd1 << K);
            end else begin
                r_rem[g]  <= r_rem[g-1];
                r_root[g] <= r_root[g-1];
            end
        end
    end

    assign o_radius = r_root[SQRT_STEPS];

endmodule

// ===== src/box_muller_gaussian_pair_unit.sv =====
// An accepted pair comes back on o_valid after the radius and output scaling pipelines.
// Throughput: one pair per cycle; busy is low whenever reset is released.
// Depth is set by the 30-stage log2 squaring chain and the 31-stage root chain.
// Reset clears the valid pipeline and loads mean 0, deviation 1.0, no rounding.
// Results are strobed for one cycle; the receiver cannot stall.
// Top level: Box-Muller transform from two uniform words to a Gaussian pair.
module box_muller_gaussian_pair_unit import bmg_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [31:0] i_u_word,
    input  logic [31:0] i_v_word,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    output logic        busy,
    output logic        o_valid,
    output logic signed [31:0] o_sample_sin,
    output logic signed [31:0] o_sample_cos,
    output logic        o_saturated
);

    localparam int DLY = RAD_LAT - TRIG_LAT;
    localparam int HS  = 2 * COS_TERMS;
    localparam logic signed [37:0] HALF_LSB  = 38'sd1 <<< (FRAC_BITS - 1);
    localparam logic [37:0]        FRAC_MASK = (38'd1 << FRAC_BITS) - 38'd1;
    localparam logic signed [37:0] HI_PLAIN  = 38'sd2147483647;
    localparam logic signed [37:0] HI_ROUND  = (38'sd1 <<< 31) - (38'sd1 <<< FRAC_BITS);
    localparam logic signed [37:0] LO_LIM    = -(38'sd1 <<< 31);

    typedef struct packed {
        logic [2:0]  oct;
        logic [30:0] s;
        logic [30:0] c;
    } t_trig;

    // Configuration
    logic signed [31:0] r_mean;
    logic [31:0]        r_std;
    logic               r_round;

    // Control
    logic                 accept;
    logic [TOTAL_LAT-1:0] r_vld;

    // Radius
    logic [30:0] rad_c;

    // Trig front
    logic [2:0]  r_oct1, r_oct2, r_oct3;
    logic [29:0] r_t;
    logic [60:0] x_full;
    logic [29:0] r_xa;
    logic [59:0] x2_full;
    logic [29:0] r_x2, r_x3;

    // Series pipeline
    logic [29:0] r_qs  [COS_TERMS];
    logic [29:0] r_qc  [COS_TERMS];
    logic [30:0] r_ps  [COS_TERMS];
    logic [30:0] r_pc  [COS_TERMS];
    logic [29:0] r_hx2 [HS];
    logic [29:0] r_hx  [HS];
    logic [2:0]  r_hoct[HS];

    // Alignment line
    t_trig r_dl [DLY];
    t_trig trig_al;

    // Scaling
    logic        sel_swap;
    logic [30:0] mag_s, mag_c;
    logic [61:0] mc_s, mc_c;
    logic [31:0] r_f1_s, r_f1_c;
    logic        r_f1_ns, r_f1_nc;
    logic [63:0] r_f2_s, r_f2_c;
    logic        r_f2_ns, r_f2_nc;
    logic [63:0] rnd_s, rnd_c;
    logic [35:0] r_f3_s, r_f3_c;
    logic        r_f3_ns, r_f3_nc;
    logic signed [37:0] mean_x;
    logic signed [37:0] r_f4_s, r_f4_c;
    logic [32:0] clip_s, clip_c;
    logic signed [31:0] r_out_s, r_out_c;
    logic        r_out_sat;

    // Round to integer when asked, then clip; returns {clipped, value}
    function automatic logic [32:0] f_clip(input logic signed [37:0] v, input logic rnd);
        logic signed [37:0] vr;
        logic signed [37:0] hi;
        logic [32:0]        res;
        vr  = rnd ? $signed(38'(v + HALF_LSB) & ~FRAC_MASK) : v;
        hi  = rnd ? HI_ROUND : HI_PLAIN;
        res = {1'b0, vr[31:0]};
        if (vr > hi) begin
            res = {1'b1, hi[31:0]};
        end else if (vr < LO_LIM) begin
            res = {1'b1, LO_LIM[31:0]};
        end
        return res;
    endfunction

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= '0;
            r_std   <= STD_RESET;
            r_round <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MEAN:  r_mean  <= $signed(i_cfg_wdata);
                CFG_STD:   r_std   <= i_cfg_wdata;
                CFG_ROUND: r_round <= i_cfg_wdata[0];
                default:   r_round <= r_round;
            endcase
        end
    end

    // Advance valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], accept};
        end
    end

    bmg_radius u_radius (
        .i_clk    (i_clk),
        .i_word   (i_u_word),
        .o_radius (rad_c)
    );

    // Fold the angle into one octant
    always_ff @(posedge i_clk) begin
        r_oct1 <= i_v_word[31:29];
        r_t    <= i_v_word[29] ? (30'd1 << 29) - {1'b0, i_v_word[28:0]}
                               : {1'b0, i_v_word[28:0]};
    end

    // Residual angle in radians, then its square
    assign x_full = r_t * PI_Q29;
    always_ff @(posedge i_clk) begin
        r_xa   <= x_full[59:30];
        r_oct2 <= r_oct1;
    end

    assign x2_full = r_xa * r_xa;
    always_ff @(posedge i_clk) begin
        r_x2   <= x2_full[59:30];
        r_x3   <= r_xa;
        r_oct3 <= r_oct2;
    end

    // Horner steps: multiply by x^2, divide by the term constant, subtract from one
    for (genvar j = 0; j < COS_TERMS; j++) begin : g_term
        logic [30:0] ps_in, pc_in;
        logic [29:0] x2_in, x_in;
        logic [2:0]  oct_in;
        logic [60:0] mq_s, mq_c;
        logic [60:0] dq_c;

        if (j == 0) begin : g_first
            assign ps_in  = Q30_ONE;
            assign pc_in  = Q30_ONE;
            assign x2_in  = r_x2;
            assign x_in   = r_x3;
            assign oct_in = r_oct3;
        end else begin : g_next
            assign ps_in  = r_ps[j-1];
            assign pc_in  = r_pc[j-1];
            assign x2_in  = r_hx2[2*j-1];
            assign x_in   = r_hx[2*j-1];
            assign oct_in = r_hoct[2*j-1];
        end

        // Last sine step multiplies by x instead of x^2
        assign mq_s = (j < SIN_TERMS) ? x2_in * ps_in : x_in * ps_in;
        assign mq_c = x2_in * pc_in;

        always_ff @(posedge i_clk) begin
            r_qs[j]        <= mq_s[59:30];
            r_qc[j]        <= mq_c[59:30];
            r_hx2[2*j]     <= x2_in;
            r_hx[2*j]      <= x_in;
            r_hoct[2*j]    <= oct_in;
            r_hx2[2*j+1]   <= r_hx2[2*j];
            r_hx[2*j+1]    <= r_hx[2*j];
            r_hoct[2*j+1]  <= r_hoct[2*j];
        end

        assign dq_c = r_qc[j] * COS_RECIP[j];
        always_ff @(posedge i_clk) begin
            r_pc[j] <= Q30_ONE - {1'b0, 30'(dq_c >> COS_SHIFT[j])};
        end

        if (j < SIN_TERMS) begin : g_sdiv
            logic [60:0] dq_s;
            assign dq_s = r_qs[j] * SIN_RECIP[j];
            always_ff @(posedge i_clk) begin
                r_ps[j] <= Q30_ONE - {1'b0, 30'(dq_s >> SIN_SHIFT[j])};
            end
        end else begin : g_shold
            always_ff @(posedge i_clk) begin
                r_ps[j] <= {1'b0, r_qs[j]};
            end
        end
    end

    // Delay trig results to meet the radius
    always_ff @(posedge i_clk) begin
        r_dl[0] <= '{oct: r_hoct[HS-1], s: r_ps[COS_TERMS-1], c: r_pc[COS_TERMS-1]};
        for (int i = 1; i < DLY; i++) begin
            r_dl[i] <= r_dl[i-1];
        end
    end
    assign trig_al = r_dl[DLY-1];

    // Map octant, multiply radius by trig magnitude
    assign sel_swap = trig_al.oct[0] ^ trig_al.oct[1];
    assign mag_s    = sel_swap ? trig_al.c : trig_al.s;
    assign mag_c    = sel_swap ? trig_al.s : trig_al.c;
    assign mc_s     = rad_c * mag_s;
    assign mc_c     = rad_c * mag_c;

    always_ff @(posedge i_clk) begin
        r_f1_s  <= 32'(mc_s >> 30);
        r_f1_c  <= 32'(mc_c >> 30);
        r_f1_ns <= trig_al.oct[2];
        r_f1_nc <= trig_al.oct[2] ^ trig_al.oct[1];
    end

    // Scale by standard deviation
    always_ff @(posedge i_clk) begin
        r_f2_s  <= r_std * r_f1_s;
        r_f2_c  <= r_std * r_f1_c;
        r_f2_ns <= r_f1_ns;
        r_f2_nc <= r_f1_nc;
    end

    // Round half up to Q.FRAC_BITS
    assign rnd_s = r_f2_s + (64'd1 << 27);
    assign rnd_c = r_f2_c + (64'd1 << 27);
    always_ff @(posedge i_clk) begin
        r_f3_s  <= rnd_s[63:28];
        r_f3_c  <= rnd_c[63:28];
        r_f3_ns <= r_f2_ns;
        r_f3_nc <= r_f2_nc;
    end

    // Add or subtract from the mean
    assign mean_x = 38'(r_mean);
    always_ff @(posedge i_clk) begin
        r_f4_s <= r_f3_ns ? mean_x - $signed({2'd0, r_f3_s}) : mean_x + $signed({2'd0, r_f3_s});
        r_f4_c <= r_f3_nc ? mean_x - $signed({2'd0, r_f3_c}) : mean_x + $signed({2'd0, r_f3_c});
    end

    // Round and clip into the output register
    assign clip_s = f_clip(r_f4_s, r_round);
    assign clip_c = f_clip(r_f4_c, r_round);
    always_ff @(posedge i_clk) begin
        r_out_s   <= $signed(clip_s[31:0]);
        r_out_c   <= $signed(clip_c[31:0]);
        r_out_sat <= clip_s[32] | clip_c[32];
    end

    assign o_valid      = r_vld[TOTAL_LAT-1];
    assign o_sample_sin = r_out_s;
    assign o_sample_cos = r_out_c;
    assign o_saturated  = r_out_sat;

endmodule

// ===== src/bmg_checker.sv =====
// Port-level checks for the Box-Muller Gaussian pair unit and their binding.
module bmg_checker import bmg_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [31:0] o_sample_sin,
    input logic [31:0] o_sample_cos,
    input logic        o_saturated
);

    localparam logic [31:0] S_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN  = 32'h8000_0000;
    localparam logic [31:0] S_RMAX = 32'h8000_0000 - (32'd1 << FRAC_BITS);

    // Every result traces back to a transfer a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, TOTAL_LAT))
        else $error("result strobe without matching input transfer");

    // Reset empties the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // A clipped pair has a sample on a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_sample_sin == S_MAX || o_sample_sin == S_MIN || o_sample_sin == S_RMAX ||
             o_sample_cos == S_MAX || o_sample_cos == S_MIN || o_sample_cos == S_RMAX))
        else $error("saturation flag without a sample at a limit");

endmodule

bind box_muller_gaussian_pair_unit bmg_checker #(.FRAC_BITS(FRAC_BITS)) u_bmg_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the Box-Muller Gaussian pair unit.
`timescale 1ns / 100ps

module tb_top;
    import bmg_pkg::*;

    localparam int FB        = FRAC_BITS_DEF;
    localparam int N_RANDOM  = 1500;
    localparam int MAX_CYC   = 400000;

    // Register index that maps to no register
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] i_u_word = '0;
    logic [31:0] i_v_word = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic        busy;
    logic        o_valid;
    logic signed [31:0] o_sample_sin;
    logic signed [31:0] o_sample_cos;
    logic        o_saturated;

    typedef struct packed {
        logic signed [31:0] s_sin;
        logic signed [31:0] s_cos;
        logic               sat;
    } gauss_pair_t;

    gauss_pair_t pair_q[$];

    // Shadow copy of the configuration
    logic signed [31:0] cfg_mean = 32'sd0;
    logic [31:0]        cfg_std  = STD_RESET;
    logic               cfg_round = 1'b0;

    int cycle_cnt = 0;
    int mismatch_cnt = 0;
    int pair_cnt = 0;
    int sat_cnt = 0;
    bit gap_on = 1'b1;

    box_muller_gaussian_pair_unit u_top (.*);

    always #2 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYC) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("** box_muller_gaussian_pair_unit: FAILED **");
            $finish;
        end
    end

    // Integer square root, floor
    function automatic logic [63:0] isqrt(input logic [63:0] a);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > a) b = b >> 2;
        while (b != 0) begin
            if (a >= r + b) begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Radius sqrt(-2 ln u) in Q.28
    function automatic logic [63:0] radius_q28(input logic [31:0] w);
        logic [63:0] x, m, frac, n, r;
        int e;
        x = {32'd0, w} + 64'd1;
        e = 0;
        while (e < 32 && (x >> (e + 1)) != 0) e++;
        m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
        frac = 0;
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        n = (64'd32 << 30) - ((64'(e) << 30) | frac);
        r = ((n >> 2) * 64'(TWO_LN2_Q30)) >> 28;
        return isqrt(r << 26);
    endfunction

    // Sine and cosine of the angle word, Q.30 signed
    function automatic void angle_trig(input logic [31:0] ph,
                                       output logic signed [63:0] sn,
                                       output logic signed [63:0] cs);
        int unsigned ds[5] = '{110, 72, 42, 20, 6};
        int unsigned dc[6] = '{132, 90, 56, 30, 12, 2};
        logic [2:0]  oct;
        logic [63:0] t, x, x2, p, s, c, one;
        one = 64'd1 << 30;
        oct = ph[31:29];
        t = {35'd0, ph[28:0]};
        if (oct[0]) t = (64'd1 << 29) - t;
        x = (t * 64'(PI_Q29)) >> 30;
        x2 = (x * x) >> 30;
        p = one;
        for (int i = 0; i < 5; i++) p = one - ((x2 * p) >> 30) / ds[i];
        s = (x * p) >> 30;
        p = one;
        for (int i = 0; i < 6; i++) p = one - ((x2 * p) >> 30) / dc[i];
        c = p;
        case (oct)
            3'd0: begin sn = s;  cs = c;  end
            3'd1: begin sn = c;  cs = s;  end
            3'd2: begin sn = c;  cs = -s; end
            3'd3: begin sn = s;  cs = -c; end
            3'd4: begin sn = -s; cs = -c; end
            3'd5: begin sn = -c; cs = -s; end
            3'd6: begin sn = -c; cs = s;  end
            default: begin sn = -s; cs = c; end
        endcase
    endfunction

    // Scale, offset, round and clip one sample
    function automatic logic signed [31:0] scale_sample(input logic [63:0] c,
            input logic signed [63:0] tr, inout logic sat);
        logic [63:0] mag, m, prod;
        logic signed [63:0] v, hi;
        mag = tr < 0 ? -tr : tr;
        m = (c * mag) >> 30;
        prod = (64'(cfg_std) * m + (64'd1 << 27)) >> 28;
        v = tr < 0 ? 64'(cfg_mean) - $signed(prod) : 64'(cfg_mean) + $signed(prod);
        hi = 64'sd2147483647;
        if (cfg_round) begin
            v = v + (64'sd1 <<< (FB - 1));
            v[FB-1:0] = '0;
            hi = 64'sd2147483648 - (64'sd1 <<< FB);
        end
        if (v > hi) begin
            v = hi;
            sat = 1'b1;
        end
        if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
            sat = 1'b1;
        end
        return v[31:0];
    endfunction

    function automatic gauss_pair_t predict_pair(input logic [31:0] uw, input logic [31:0] vw);
        gauss_pair_t g;
        logic [63:0] c;
        logic signed [63:0] sn, cs;
        logic sat;
        sat = 1'b0;
        c = radius_q28(uw);
        angle_trig(vw, sn, cs);
        g.s_sin = scale_sample(c, sn, sat);
        g.s_cos = scale_sample(c, cs, sat);
        g.sat = sat;
        return g;
    endfunction

    // Transfer one pair after a random gap; start stays high for back-to-back pairs
    task automatic send_pair(input logic [31:0] uw, input logic [31:0] vw);
        int gap;
        gap = gap_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_u_word <= uw;
        i_v_word <= vw;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pair_q.push_back(predict_pair(uw, vw));
        @(negedge i_clk);
    endtask

    // Drop start and wait until every pending result has come back
    task automatic drain();
        start <= 1'b0;
        while (pair_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write one register once the pipeline is empty
    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MEAN:  cfg_mean = val;
            CFG_STD:   cfg_std = val;
            CFG_ROUND: cfg_round = val[0];
            default: ;
        endcase
    endtask

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin
        gauss_pair_t exp_p;
        if (i_rst_n && o_valid) begin
            pair_cnt++;
            if (o_saturated) sat_cnt++;
            if (pair_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result at cycle %0d", cycle_cnt);
            end else begin
                exp_p = pair_q.pop_front();
                if (o_sample_sin !== exp_p.s_sin || o_sample_cos !== exp_p.s_cos ||
                        o_saturated !== exp_p.sat) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp sin %h cos %h sat %b, got sin %h cos %h sat %b",
                                 exp_p.s_sin, exp_p.s_cos, exp_p.sat,
                                 o_sample_sin, o_sample_cos, o_saturated);
                end
            end
        end
    end

    // Directed corners of both words under the reset configuration
    task automatic test_corners();
        logic [31:0] vs[8] = '{32'h0, 32'h2000_0000, 32'h4000_0000, 32'h6000_0000,
                               32'h8000_0000, 32'hA000_0000, 32'hFFFF_FFFF, 32'h1FFF_FFFF};
        foreach (vs[i]) send_pair(32'h0, vs[i]);
        send_pair(32'hFFFF_FFFF, 32'h1234_5678);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h0000_0001, 32'h5555_5555);
        send_pair(32'h7FFF_FFFF, 32'hAAAA_AAAA);
        send_pair(32'h8000_0000, 32'h0000_0001);
        send_pair(32'hFFFF_FFFE, 32'hE000_0000);
        drain();
    endtask

    // Saturation and rounding corners at extreme register settings
    task automatic test_extremes();
        write_cfg(CFG_STD, 32'hFFFF_FFFF);
        write_cfg(CFG_MEAN, 32'h7FFF_FFFF);
        send_pair(32'h0, 32'h0);
        send_pair(32'h0, 32'h8000_0000);
        write_cfg(CFG_MEAN, 32'h8000_0000);
        send_pair(32'h0, 32'h4000_0000);
        send_pair(32'hFFFF_FFFF, 32'h0);
        write_cfg(CFG_ROUND, 32'h1);
        send_pair(32'h0, 32'h2000_0000);
        write_cfg(CFG_MEAN, 32'h7FFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'h0);
        send_pair(32'h0, 32'hC000_0000);
        write_cfg(CFG_STD, 32'h0);
        write_cfg(CFG_MEAN, 32'h0000_8000);
        send_pair(32'h1234_5678, 32'h9ABC_DEF0);
        write_cfg(CFG_MEAN, 32'hFFFF_7FFF);
        send_pair(32'h1234_5678, 32'h9ABC_DEF0);
        // Unknown index must leave configuration alone
        write_cfg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_pair(32'h0, 32'h0);
        drain();
    endtask

    // Random pairs across several random configurations
    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: write_cfg(CFG_STD, STD_RESET);
                1: write_cfg(CFG_STD, $urandom_range(0, 32'h0010_0000));
                default: write_cfg(CFG_STD, $urandom());
            endcase
            write_cfg(CFG_MEAN, (ph < 2) ? $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000
                                         : $urandom());
            write_cfg(CFG_ROUND, ph % 2);
            gap_on = (ph != 3);
            for (int i = 0; i < N_RANDOM / 6; i++)
                send_pair($urandom(), $urandom());
        end
        gap_on = 1'b1;
        drain();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_corners();
        test_extremes();
        test_random();
        repeat (TOTAL_LAT + 20) @(negedge i_clk);
        $display("covered %0d result pairs, %0d saturated, over varied mean/deviation/rounding",
                 pair_cnt, sat_cnt);
        if (mismatch_cnt == 0 && pair_q.size() == 0) begin
            $display("** box_muller_gaussian_pair_unit: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_cnt, pair_q.size());
            $display("** box_muller_gaussian_pair_unit: FAILED **");
        end
        $finish;
    end

endmodule
